/* rtl/core/tpic_pkg.sv */
// Shared types and constants for the transmit power index calculator.
`timescale 1ns / 1ps
package tpic_pkg;

  localparam int RateIndexMax  = 32;
  localparam int MaxPowerIndex = 107;
  localparam int RateW         = 6;
  localparam int PwrIdxW       = 7;
  localparam int CfgAddrW      = 3;
  localparam int CfgDataW      = 16;

  // Per-rate power backoff, half-dBm
  localparam logic [4:0] OffsetDefault = 5'd10;
  localparam logic [4:0] OffsetSub5    = 5'd15;
  localparam logic [4:0] OffsetSub6    = 5'd17;
  localparam logic [4:0] OffsetSub7    = 5'd20;
  localparam logic [3:0] MimoBackoff   = 4'd6;
  localparam logic [3:0] Band5Bonus    = 4'd9;
  localparam logic [3:0] LastBonus     = 4'd5;

  typedef enum logic [CfgAddrW-1:0] {
    CfgMaxPower2g = 3'd0,
    CfgMaxPower5g = 3'd1,
    CfgCalibVolt  = 3'd2,
    CfgLiveVolt   = 3'd3,
    CfgCurTemp    = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FIdle,
    FMul,
    FDiv,
    FFix,
    FTdiv,
    FPush
  } front_state_e;

  typedef struct packed {
    logic [7:0]        channel;
    logic [7:0]        a_channel;
    logic [7:0]        b_channel;
    logic [7:0]        a_power;
    logic [7:0]        b_power;
    logic [7:0]        a_gain;
    logic [7:0]        b_gain;
    logic [7:0]        a_temp;
    logic [7:0]        b_temp;
    logic [6:0]        limit;
    logic signed [7:0] atten;
    logic              band5;
  } item_t;

  typedef struct packed {
    logic [7:0]        power;
    logic [7:0]        gain;
    logic signed [9:0] tdiff;
    logic [6:0]        limit;
    logic signed [7:0] atten;
    logic              band5;
  } job_t;

  // Temperature compensation divisor by channel group
  function automatic logic [3:0] temp_div(input logic [7:0] chan);
    logic [3:0] d;
    if (chan <= 8'd20)       d = 4'd6;
    else if (chan <= 8'd43)  d = 4'd9;
    else                     d = 4'd8;
    return d;
  endfunction

endpackage

/* rtl/core/tpic_fifo.sv */
// Two-entry job queue between front and back.
`timescale 1ns / 1ps
module tpic_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tpic_pkg::job_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output tpic_pkg::job_t  data_o
);

  tpic_pkg::job_t mem_q [2];
  logic wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/tpic_front.sv */
// Front end: input skid, interpolation and temperature compensation divides.
`timescale 1ns / 1ps
module tpic_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tpic_pkg::item_t     item_i,
  input  logic signed [8:0]   cur_temp_i,
  output logic                push_o,
  output tpic_pkg::job_t      job_o,
  input  logic                full_i
);

  logic                   hold_valid_q, hold_valid_d;
  tpic_pkg::item_t        hold_q, work_q;
  tpic_pkg::front_state_e state_q, state_d;
  logic [4:0]             cnt_q;
  logic [7:0]             den_q;
  logic                   den_zero_q;
  logic [16:0]            num_q [3];
  logic [7:0]             rem_q [3];
  logic                   neg_q [3];
  logic                   tneg_q;
  logic [7:0]             power_q, gain_q;
  logic [16:0]            num_n [3];
  logic [7:0]             rem_n [3];
  logic [8:0]             sh    [3];
  logic [9:0]             trial [3];
  logic [7:0]             y1    [3];
  logic [7:0]             y2    [3];
  logic [7:0]             res   [3];
  logic signed [17:0]     q     [3];
  logic signed [17:0]     t     [3];
  logic signed [17:0]     h     [3];
  logic signed [8:0]      dx, dd;
  logic signed [8:0]      dy    [3];
  logic [7:0]             dx_mag, dd_mag;
  logic [7:0]             dy_mag [3];
  logic signed [10:0]     tnum;
  logic [9:0]             tmag;
  logic                   take;

  assign in_ready_o = !hold_valid_q;
  assign take       = (state_q == tpic_pkg::FIdle) && hold_valid_q;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (in_valid_i && in_ready_o) hold_valid_d = 1'b1;
    else if (take)                hold_valid_d = 1'b0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpic_pkg::FIdle: if (hold_valid_q) state_d = tpic_pkg::FMul;
      tpic_pkg::FMul:  state_d = tpic_pkg::FDiv;
      tpic_pkg::FDiv:  if (cnt_q == 5'd0) state_d = tpic_pkg::FFix;
      tpic_pkg::FFix:  state_d = tpic_pkg::FTdiv;
      tpic_pkg::FTdiv: if (cnt_q == 5'd0) state_d = tpic_pkg::FPush;
      tpic_pkg::FPush: if (!full_i) state_d = tpic_pkg::FIdle;
      default:         state_d = tpic_pkg::FIdle;
    endcase
  end

  // outputs
  always_comb begin
    push_o      = (state_q == tpic_pkg::FPush) && !full_i;
    job_o.power = power_q;
    job_o.gain  = gain_q;
    job_o.tdiff = tneg_q ? -$signed({1'b0, num_q[0][8:0]}) : $signed({1'b0, num_q[0][8:0]});
    job_o.limit = work_q.limit;
    job_o.atten = work_q.atten;
    job_o.band5 = work_q.band5;
  end

  // per-lane datapath
  always_comb begin
    y1[0] = work_q.a_power; y2[0] = work_q.b_power;
    y1[1] = work_q.a_gain;  y2[1] = work_q.b_gain;
    y1[2] = work_q.a_temp;  y2[2] = work_q.b_temp;
    dx = $signed({1'b0, work_q.channel}) - $signed({1'b0, work_q.a_channel});
    dd = $signed({1'b0, work_q.b_channel}) - $signed({1'b0, work_q.a_channel});
    dx_mag = dx[8] ? 8'(-dx) : dx[7:0];
    dd_mag = dd[8] ? 8'(-dd) : dd[7:0];
    for (int i = 0; i < 3; i++) begin
      dy[i]     = $signed({1'b0, y2[i]}) - $signed({1'b0, y1[i]});
      dy_mag[i] = dy[i][8] ? 8'(-dy[i]) : dy[i][7:0];
      sh[i]     = {rem_q[i], num_q[i][16]};
      trial[i]  = {1'b0, sh[i]} - {2'b0, den_q};
      rem_n[i]  = trial[i][9] ? sh[i][7:0] : trial[i][7:0];
      num_n[i]  = {num_q[i][15:0], !trial[i][9]};
      q[i]      = neg_q[i] ? -$signed({1'b0, num_q[i]}) : $signed({1'b0, num_q[i]});
      t[i]      = q[i] + 18'sd1;
      h[i]      = t[i][17] ? -((-t[i]) >>> 1) : (t[i] >>> 1);
      res[i]    = den_zero_q ? y1[i] : 8'(y1[i] + h[i][7:0]);
    end
    tnum = ($signed({cur_temp_i[8], cur_temp_i}) - $signed({2'b0, res[2]})) <<< 1;
    tmag = tnum[10] ? 10'(-tnum) : tnum[9:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      state_q      <= tpic_pkg::FIdle;
    end else begin
      hold_valid_q <= hold_valid_d;
      state_q      <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) hold_q <= item_i;
    if (take) work_q <= hold_q;
    case (state_q)
      tpic_pkg::FMul: begin
        den_q      <= dd_mag;
        den_zero_q <= dd_mag == 8'd0;
        cnt_q      <= 5'd16;
        for (int i = 0; i < 3; i++) begin
          num_q[i] <= {{8'd0, dx_mag} * {8'd0, dy_mag[i]}, 1'b0};
          rem_q[i] <= 8'd0;
          neg_q[i] <= dx[8] ^ dy[i][8] ^ dd[8];
        end
      end
      tpic_pkg::FDiv, tpic_pkg::FTdiv: begin
        cnt_q <= cnt_q - 5'd1;
        for (int i = 0; i < 3; i++) begin
          num_q[i] <= num_n[i];
          rem_q[i] <= rem_n[i];
        end
      end
      tpic_pkg::FFix: begin
        power_q  <= res[0];
        gain_q   <= res[1];
        den_q    <= {4'd0, tpic_pkg::temp_div(work_q.channel)};
        cnt_q    <= 5'd9;
        tneg_q   <= tnum[10];
        num_q[0] <= {tmag, 7'd0};
        rem_q[0] <= 8'd0;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/tpic_back.sv */
// Back end: walks the rate indexes of one job, one result per cycle while the output is not stalled.
`timescale 1ns / 1ps
module tpic_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  job_valid_i,
  input  tpic_pkg::job_t                        job_i,
  output logic                                  job_pop_o,
  input  logic [5:0]                            max_power_2g_i,
  input  logic [5:0]                            max_power_5g_i,
  input  logic signed [15:0]                    calib_voltage_i,
  input  logic signed [15:0]                    live_voltage_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [tpic_pkg::RateW-1:0]            rate_index_o,
  output logic [tpic_pkg::PwrIdxW-1:0]          power_index_o,
  output logic                                  last_o
);

  localparam logic [tpic_pkg::RateW-1:0] RateLast = tpic_pkg::RateW'(tpic_pkg::RateIndexMax);
  localparam logic signed [11:0] IdxMax = 12'(tpic_pkg::MaxPowerIndex);

  logic [tpic_pkg::RateW-1:0]   r_q, r_d;
  logic                         out_valid_q, out_valid_d;
  logic [tpic_pkg::RateW-1:0]   rate_q;
  logic [tpic_pkg::PwrIdxW-1:0] pidx_q;
  logic                         last_q;
  logic                         load, is_last, mimo;
  logic signed [16:0]           vd;
  logic signed [2:0]            vdiff;
  logic [5:0]                   maxpwr;
  logic [4:0]                   off;
  logic signed [8:0]            chmax, pwr;
  logic signed [11:0]           idx;
  logic [tpic_pkg::PwrIdxW-1:0] idx_clamped;

  assign load      = job_valid_i && (!out_valid_q || out_ready_i);
  assign is_last   = r_q == RateLast;
  assign job_pop_o = load && is_last;
  assign mimo      = r_q[3];

  always_comb begin
    vd = $signed({live_voltage_i[15], live_voltage_i})
       - $signed({calib_voltage_i[15], calib_voltage_i});
    if (vd >= 17'sd7 && vd <= 17'sd13)        vdiff = 3'sd2;
    else if (vd <= -17'sd7 && vd >= -17'sd13)  vdiff = -3'sd1;
    else if (vd <= -17'sd14 && vd >= -17'sd20) vdiff = -3'sd2;
    else                                       vdiff = 3'sd0;

    maxpwr = job_i.band5 ? max_power_5g_i : max_power_2g_i;
    case (r_q[2:0])
      3'd5:    off = tpic_pkg::OffsetSub5;
      3'd6:    off = tpic_pkg::OffsetSub6;
      3'd7:    off = tpic_pkg::OffsetSub7;
      default: off = tpic_pkg::OffsetDefault;
    endcase
    chmax = $signed({1'b0, job_i.limit, 1'b0})
          - (mimo ? $signed({5'd0, tpic_pkg::MimoBackoff}) : 9'sd0);
    pwr   = $signed({3'd0, maxpwr}) - $signed({4'd0, off});
    if (pwr > chmax) pwr = chmax;

    idx = $signed({4'd0, job_i.gain}) - 12'(pwr) + $signed({4'd0, job_i.power})
        - 12'(job_i.tdiff) - 12'(vdiff);
    if (mimo)         idx = idx + 12'(job_i.atten);
    if (job_i.band5)  idx = idx + $signed({8'd0, tpic_pkg::Band5Bonus});
    if (is_last)      idx = idx + $signed({8'd0, tpic_pkg::LastBonus});
    if (idx < 12'sd0)        idx_clamped = '0;
    else if (idx > IdxMax)   idx_clamped = IdxMax[tpic_pkg::PwrIdxW-1:0];
    else                     idx_clamped = idx[tpic_pkg::PwrIdxW-1:0];

    out_valid_d = out_valid_q;
    if (load)             out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    r_d = r_q;
    if (load) r_d = is_last ? '0 : r_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      r_q         <= r_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rate_q <= r_q;
      pidx_q <= idx_clamped;
      last_q <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rate_index_o  = rate_q;
  assign power_index_o = pidx_q;
  assign last_o        = last_q;

  a_last_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> rate_index_o == RateLast)
    else $error("last flag on wrong rate index");
  a_job_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_q != '0 |-> job_valid_i)
    else $error("job left queue mid-run");
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> out_valid_o && last_o)
    else $error("job popped before last result");

endmodule

/* rtl/core/tx_power_index_calc.sv */
// Top level of the transmit power index calculator.
// Path from input transfer to the first result valid: the input skid register, one
//   multiply, 17 interpolation divide steps, one fixup, 10 temperature divide steps, the
//   push into the queue, and the back end's output register.
// Throughput: RATE_INDEX_MAX+1 = 33 results per item, the back end emitting one result
//   per cycle while out_ready_i is high; the front end's divider loop runs underneath it.
// Reset: asynchronous, active low; clears queue, state machines and registers to
//   their defaults (38, 38, 0, 0, 0). No clearing pass.
`timescale 1ns / 1ps
module tx_power_index_calc (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tpic_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [tpic_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          channel_i,
  input  logic [7:0]                          sample_a_channel_i,
  input  logic [7:0]                          sample_b_channel_i,
  input  logic [7:0]                          sample_a_power_i,
  input  logic [7:0]                          sample_b_power_i,
  input  logic [7:0]                          sample_a_gain_i,
  input  logic [7:0]                          sample_b_gain_i,
  input  logic [7:0]                          sample_a_temp_i,
  input  logic [7:0]                          sample_b_temp_i,
  input  logic [6:0]                          channel_limit_i,
  input  logic signed [7:0]                   mimo_atten_i,
  input  logic                                is_5ghz_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tpic_pkg::RateW-1:0]          rate_index_o,
  output logic [tpic_pkg::PwrIdxW-1:0]        power_index_o,
  output logic                                last_o
);

  // configuration registers
  logic [5:0]         max2_q, max5_q;
  logic signed [15:0] cal_q, live_q;
  logic signed [8:0]  temp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max2_q <= 6'd38;
      max5_q <= 6'd38;
      cal_q  <= '0;
      live_q <= '0;
      temp_q <= '0;
    end else if (cfg_we_i) begin
      case (tpic_pkg::cfg_idx_e'(cfg_addr_i))
        tpic_pkg::CfgMaxPower2g: max2_q <= cfg_wdata_i[5:0];
        tpic_pkg::CfgMaxPower5g: max5_q <= cfg_wdata_i[5:0];
        tpic_pkg::CfgCalibVolt:  cal_q  <= cfg_wdata_i;
        tpic_pkg::CfgLiveVolt:   live_q <= cfg_wdata_i;
        tpic_pkg::CfgCurTemp:    temp_q <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  tpic_pkg::item_t item;
  tpic_pkg::job_t  push_job, head_job;
  logic            push, full, head_valid, pop;

  always_comb begin
    item.channel   = channel_i;
    item.a_channel = sample_a_channel_i;
    item.b_channel = sample_b_channel_i;
    item.a_power   = sample_a_power_i;
    item.b_power   = sample_b_power_i;
    item.a_gain    = sample_a_gain_i;
    item.b_gain    = sample_b_gain_i;
    item.a_temp    = sample_a_temp_i;
    item.b_temp    = sample_b_temp_i;
    item.limit     = channel_limit_i;
    item.atten     = mimo_atten_i;
    item.band5     = is_5ghz_i;
  end

  // front: interpolation and temperature compensation
  tpic_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .item_i     (item),
    .cur_temp_i (temp_q),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (full)
  );

  // short queue decouples the divider loop from the result stream
  tpic_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .data_o      (head_job)
  );

  // back: one power index per rate per cycle while the output is not stalled
  tpic_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i     (head_valid),
    .job_i           (head_job),
    .job_pop_o       (pop),
    .max_power_2g_i  (max2_q),
    .max_power_5g_i  (max5_q),
    .calib_voltage_i (cal_q),
    .live_voltage_i  (live_q),
    .out_valid_o, .out_ready_i,
    .rate_index_o, .power_index_o, .last_o
  );

endmodule

/* test/tb.sv */
// Testbench for the transmit power index calculator: random and directed jobs, scoreboard check.
`timescale 1ns / 1ps
module tb;

  // One expected per-rate result
  typedef struct {
    logic [tpic_pkg::RateW-1:0]   rate;
    logic [tpic_pkg::PwrIdxW-1:0] pidx;
    logic                         last;
  } rate_res_t;

  // Scoreboard: predicts all rate results of a job and checks them in order
  class power_table_sb;
    rate_res_t pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned max2, max5;
    int cal_volt, live_volt, cur_temp;

    function void set_reg(tpic_pkg::cfg_idx_e idx, logic [15:0] val);
      case (idx)
        tpic_pkg::CfgMaxPower2g: max2 = val[5:0];
        tpic_pkg::CfgMaxPower5g: max5 = val[5:0];
        tpic_pkg::CfgCalibVolt:  cal_volt = $signed(val);
        tpic_pkg::CfgLiveVolt:   live_volt = $signed(val);
        tpic_pkg::CfgCurTemp:    cur_temp = $signed(val[8:0]);
        default: ;
      endcase
    endfunction

    // Linear interpolation with rounded division, truncated to 8 bits
    function int lerp8(int x, int x1, int y1, int x2, int y2);
      int r;
      if (x1 == x2) begin
        r = y1;
      end else begin
        r = y1 + ((2 * ((x - x1) * (y2 - y1))) / (x2 - x1) + 1) / 2;
      end
      return r & 8'hFF;
    endfunction

    function void note_job(tpic_pkg::item_t it);
      int pwr_i, gain_i, temp_i, vcomp, tcomp, maxp, div, chmax, p, idx;
      rate_res_t e;
      pwr_i  = lerp8(it.channel, it.a_channel, it.a_power, it.b_channel, it.b_power);
      gain_i = lerp8(it.channel, it.a_channel, it.a_gain, it.b_channel, it.b_gain);
      temp_i = lerp8(it.channel, it.a_channel, it.a_temp, it.b_channel, it.b_temp);
      maxp = it.band5 ? max5 : max2;
      vcomp = (live_volt - cal_volt) / 7;
      if (vcomp > 0) vcomp *= 2;
      if (vcomp > 2 || vcomp < -2) vcomp = 0;
      if (it.channel <= 20) div = 6;
      else if (it.channel <= 43) div = 9;
      else div = 8;
      tcomp = ((cur_temp - temp_i) * 2) / div;
      for (int r = 0; r <= tpic_pkg::RateIndexMax; r++) begin
        bool_mimo: begin
        end
        chmax = it.limit * 2;
        if ((r / 8) % 2) chmax -= tpic_pkg::MimoBackoff;
        case (r % 8)
          5: p = maxp - tpic_pkg::OffsetSub5;
          6: p = maxp - tpic_pkg::OffsetSub6;
          7: p = maxp - tpic_pkg::OffsetSub7;
          default: p = maxp - tpic_pkg::OffsetDefault;
        endcase
        if (p > chmax) p = chmax;
        idx = gain_i - (p - pwr_i) - tcomp - vcomp;
        if ((r / 8) % 2) idx += it.atten;
        if (it.band5) idx += tpic_pkg::Band5Bonus;
        if (r == tpic_pkg::RateIndexMax) idx += tpic_pkg::LastBonus;
        if (idx < 0) idx = 0;
        else if (idx > tpic_pkg::MaxPowerIndex) idx = tpic_pkg::MaxPowerIndex;
        e.rate = tpic_pkg::RateW'(r);
        e.pidx = tpic_pkg::PwrIdxW'(idx);
        e.last = (r == tpic_pkg::RateIndexMax);
        pending.push_back(e);
      end
    endfunction

    function void check_result(logic [tpic_pkg::RateW-1:0] rate,
                               logic [tpic_pkg::PwrIdxW-1:0] pidx, logic last);
      rate_res_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result rate=%0d idx=%0d", $time, rate, pidx);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (rate !== e.rate) begin
        $display("%0t: rate_index exp %0d got %0d", $time, e.rate, rate);
        errors++;
      end
      if (pidx !== e.pidx) begin
        $display("%0t: power_index (rate %0d) exp %0d got %0d", $time, e.rate, e.pidx, pidx);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last (rate %0d) exp %0d got %0d", $time, e.rate, e.last, last);
        errors++;
      end
    endfunction
  endclass

  localparam int StallLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [tpic_pkg::CfgAddrW-1:0] cfg_addr_i = '0;
  logic [tpic_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  tpic_pkg::item_t job = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [tpic_pkg::RateW-1:0] rate_index_o;
  logic [tpic_pkg::PwrIdxW-1:0] power_index_o;
  logic last_o;

  // Channels on both sides of the divisor group edges at 20 and 43, plus 70/71 and 124/125
  int group_edge [8] = '{20, 21, 43, 44, 70, 71, 124, 125};

  power_table_sb sb;
  int unsigned jobs_sent;
  int unsigned quiet_cycles;
  bit stim_done;
  bit no_out_idle;

  always #1 clk_i = ~clk_i;

  tx_power_index_calc DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o,
    .channel_i(job.channel),
    .sample_a_channel_i(job.a_channel),
    .sample_b_channel_i(job.b_channel),
    .sample_a_power_i(job.a_power),
    .sample_b_power_i(job.b_power),
    .sample_a_gain_i(job.a_gain),
    .sample_b_gain_i(job.b_gain),
    .sample_a_temp_i(job.a_temp),
    .sample_b_temp_i(job.b_temp),
    .channel_limit_i(job.limit),
    .mimo_atten_i(job.atten),
    .is_5ghz_i(job.band5),
    .out_valid_o, .out_ready_i, .rate_index_o, .power_index_o, .last_o
  );

  // Transfers are sampled at the edge; the scoreboard sees the pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_job(job);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(rate_index_o, power_index_o, last_o);
  end

  // Watchdog: cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls, none during phase 5
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = no_out_idle ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Write enable stays high across back-to-back writes; the caller drops it
  task automatic write_reg(tpic_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // Registers move only with nothing in flight
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Valid stays high into the next job when there is no idle gap
  task automatic send_job(tpic_pkg::item_t it, bit idle_ok);
    int gap;
    gap = idle_ok ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    job <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    jobs_sent++;
  endtask

  function automatic tpic_pkg::item_t rand_job();
    tpic_pkg::item_t it;
    logic [95:0] rnd;
    logic [7:0] lo, hi;
    rnd = {$urandom, $urandom, $urandom};
    it = rnd[$bits(tpic_pkg::item_t)-1:0];
    // Mostly bracketed channels with sane samples
    if ($urandom_range(0, 3) != 0) begin
      lo = 8'($urandom_range(0, 200));
      hi = 8'(lo + $urandom_range(0, 55));
      it.a_channel = $urandom_range(0, 1) ? lo : hi;
      it.b_channel = (it.a_channel == lo) ? hi : lo;
      it.channel = 8'($urandom_range(lo, hi));
      it.limit = 7'($urandom_range(10, 40));
      it.atten = 8'($signed($urandom_range(0, 20)) - 10);
    end
    return it;
  endfunction

  initial begin
    tpic_pkg::item_t it;
    sb = new();
    sb.max2 = 38;
    sb.max5 = 38;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, equal sample channels, extrapolation, channel groups
    it = '0;
    send_job(it, 0);
    it = '1;
    send_job(it, 0);
    it = '0; it.channel = 30; it.a_channel = 30; it.b_channel = 30;
    it.a_power = 200; it.b_power = 5; it.a_gain = 60; it.limit = 127; it.band5 = 1;
    send_job(it, 0);
    it = '0; it.channel = 255; it.a_channel = 10; it.b_channel = 20;
    it.a_power = 0; it.b_power = 255; it.a_gain = 255; it.a_temp = 255; it.limit = 20;
    it.atten = -128;
    send_job(it, 1);
    it.channel = 0; it.atten = 127;
    send_job(it, 1);
    foreach (group_edge[k]) begin
      it = rand_job();
      it.channel = 8'(group_edge[k]);
      send_job(it, 1);
    end
    drain();

    // Register settings across the range, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(tpic_pkg::CfgMaxPower2g, 16'd20);
          write_reg(tpic_pkg::CfgMaxPower5g, 16'd50);
          write_reg(tpic_pkg::CfgCalibVolt, 16'h8000);
          write_reg(tpic_pkg::CfgLiveVolt, 16'h7FFF);
          write_reg(tpic_pkg::CfgCurTemp, 16'h0100);
        end
        1: begin
          write_reg(tpic_pkg::CfgMaxPower2g, 16'd63);
          write_reg(tpic_pkg::CfgMaxPower5g, 16'd0);
          write_reg(tpic_pkg::CfgCalibVolt, 16'd100);
          write_reg(tpic_pkg::CfgLiveVolt, 16'd107);
          write_reg(tpic_pkg::CfgCurTemp, 16'h00FF);
        end
        2: begin
          write_reg(tpic_pkg::CfgCalibVolt, 16'd100);
          write_reg(tpic_pkg::CfgLiveVolt, 16'd86);
          write_reg(tpic_pkg::CfgCurTemp, 16'h01FF);
        end
        3: begin
          write_reg(tpic_pkg::CfgLiveVolt, 16'd93);
          write_reg(tpic_pkg::CfgMaxPower2g, 16'd50);
          write_reg(tpic_pkg::CfgMaxPower5g, 16'd20);
        end
        default: begin
          write_reg(tpic_pkg::CfgMaxPower2g, 16'($urandom_range(20, 50)));
          write_reg(tpic_pkg::CfgMaxPower5g, 16'($urandom_range(20, 50)));
          write_reg(tpic_pkg::CfgCalibVolt, 16'($urandom));
          write_reg(tpic_pkg::CfgLiveVolt,
                    16'($urandom_range(0, 1) ? $urandom : sb.cal_volt + 10));
          write_reg(tpic_pkg::CfgCurTemp, 16'($urandom_range(0, 511)));
        end
      endcase
      cfg_we_i <= 1'b0;
      no_out_idle = (ph == 5);
      for (int i = 0; i < 46; i++) send_job(rand_job(), ph != 6);
      drain();
    end
    stim_done = 1;

    $display("Run covered %0d jobs and %0d per-rate results over 9 register settings.",
             jobs_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
